// File: src/rmth_pkg.sv
// Shared types for the running median block.
`timescale 1ns / 1ps
package rmth_pkg;

	// Operation the controller asks of the datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH_LO,
		OP_PUSH_UP,
		OP_REPL_LO,
		OP_REPL_UP
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic clear;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dp_sts_t;

endpackage

// File: src/running_median_two_heaps.sv
// Running median over a stream of samples, kept in a max-heap and a min-heap.
// Each word runs the heap sift loops, each level one or two memory reads and one write;
// one word in flight at a time; the result register frees the input side.
// Reset (arst_n low) empties both heaps; heap memories are not cleared.
`timescale 1ns / 1ps
module running_median_two_heaps #(
	parameter int CAPACITY = 1024,
	parameter int SAMPLE_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // sample
	input  logic        s_tuser,  // new_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // median_floor, median_has_half, stream_count
	output logic        m_tuser   // overflow
);
	import rmth_pkg::*;

	localparam int CW = $clog2(CAPACITY+1);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [CW-1:0] lo_size, up_size;
	logic [SAMPLE_WIDTH-1:0] lo_top, up_top, x_q;
	logic ovf;
	logic res_load;
	logic [SAMPLE_WIDTH:0] sum;
	logic [19:0] mf;
	logic half;
	logic [CW:0] cnt;

	always_ff @(posedge clk)
		if (s_tvalid && s_tready) x_q <= s_tdata[SAMPLE_WIDTH-1:0];

	rmth_ctrl #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_new(s_tuser),
		.x(x_q), .lo_size, .up_size, .lo_top, .up_top, .sts, .cmd,
		.out_valid(m_tvalid), .out_ready(m_tready), .res_load, .ovf_q(ovf)
	);

	rmth_heaps #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_heaps (
		.clk, .arst_n, .cmd, .x(x_q), .sts, .lo_size, .up_size, .lo_top, .up_top
	);

	assign sum = {1'b0, lo_top} + {1'b0, up_top};
	always_comb begin
		mf = '0;
		half = 1'b0;
		if (lo_size != '0) begin
			if (lo_size == up_size) begin
				mf = 20'(sum >> 1);
				half = sum[0];
			end else mf = 20'(lo_top);
		end
	end
	assign cnt = {1'b0, lo_size} + {1'b0, up_size};

	// The result word is registered as the controller leaves its output state.
	logic [31:0] res_q;
	logic        ovf_o_q;
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= {11'(cnt), half, mf};
			ovf_o_q <= ovf;
		end
	end
	assign m_tdata = res_q;
	assign m_tuser = ovf_o_q;

	ap_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && sts.busy)) else $error("accepted while heaps busy");
	ap_bal: assert property (@(posedge clk) disable iff (!arst_n)
		!sts.busy |-> (lo_size >= up_size)) else $error("heaps out of balance");
	ap_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= (CW+1)'(CAPACITY)) else $error("count beyond capacity");
endmodule

// File: src/rmth_ctrl.sv
// Controller: picks heap operations for each sample and hands out the result word.
`timescale 1ns / 1ps
module rmth_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int SAMPLE_WIDTH = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_new,
	input  logic [SAMPLE_WIDTH-1:0] x,
	input  logic [$clog2(CAPACITY+1)-1:0] lo_size,
	input  logic [$clog2(CAPACITY+1)-1:0] up_size,
	input  logic [SAMPLE_WIDTH-1:0] lo_top,
	input  logic [SAMPLE_WIDTH-1:0] up_top,
	input  rmth_pkg::dp_sts_t     sts,
	output rmth_pkg::dp_cmd_t     cmd,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  res_load,
	output logic                  ovf_q
);
	import rmth_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_DECIDE, ST_OP1, ST_OP2, ST_WAIT2, ST_OUT} state_t;
	localparam int CW = $clog2(CAPACITY+1);

	state_t state_q;
	op_t    second_q;
	logic   out_valid_q;
	logic   fresh_q;
	logic [CW-1:0] lo_n, up_n;
	logic [CW:0] total;

	// A new stream empties the heaps at the end of the decide cycle, so the
	// decision already treats both heaps as empty.
	assign lo_n = fresh_q ? '0 : lo_size;
	assign up_n = fresh_q ? '0 : up_size;
	assign total = {1'b0, lo_n} + {1'b0, up_n};
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign res_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			second_q <= OP_NONE;
			out_valid_q <= 1'b0;
			ovf_q <= 1'b0;
			fresh_q <= 1'b0;
			cmd <= '0;
		end else begin
			cmd.start <= (state_q == ST_DECIDE) ||
				(state_q == ST_OP1 && sts.done && second_q != OP_NONE);
			cmd.clear <= (state_q == ST_IDLE) && in_valid && in_new;
			if (res_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fresh_q <= in_new;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (total >= (CW+1)'(CAPACITY)) begin
						ovf_q <= 1'b1;
						cmd.op <= OP_NONE;
						second_q <= OP_NONE;
					end else begin
						ovf_q <= 1'b0;
						if (lo_n == '0) begin
							cmd.op <= OP_PUSH_LO;
							second_q <= OP_NONE;
						end else if (lo_n > up_n) begin
							if (x < lo_top) begin
								cmd.op <= OP_REPL_LO;
								second_q <= OP_PUSH_UP;
							end else begin
								cmd.op <= OP_PUSH_UP;
								second_q <= OP_NONE;
							end
						end else if (x < lo_top || up_n == '0 || x <= up_top) begin
							cmd.op <= OP_PUSH_LO;
							second_q <= OP_NONE;
						end else begin
							cmd.op <= OP_REPL_UP;
							second_q <= OP_PUSH_LO;
						end
					end
					state_q <= ST_OP1;
				end
				ST_OP1: begin
					if (sts.done) begin
						if (second_q != OP_NONE) begin
							cmd.op <= second_q;
							state_q <= ST_WAIT2;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_WAIT2: state_q <= ST_OP2;
				ST_OP2: if (sts.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (res_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: src/rmth_heaps.sv
// Datapath: two heap memories, sizes, cached tops and the sift engine.
`timescale 1ns / 1ps
module rmth_heaps #(
	parameter int CAPACITY = 1024,
	parameter int SAMPLE_WIDTH = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmth_pkg::dp_cmd_t     cmd,
	input  logic [SAMPLE_WIDTH-1:0] x,
	output rmth_pkg::dp_sts_t     sts,
	output logic [$clog2(CAPACITY+1)-1:0] lo_size,
	output logic [$clog2(CAPACITY+1)-1:0] up_size,
	output logic [SAMPLE_WIDTH-1:0] lo_top,
	output logic [SAMPLE_WIDTH-1:0] up_top
);
	import rmth_pkg::*;

	localparam int LD = (CAPACITY + 1) / 2;
	localparam int UD = CAPACITY / 2;
	localparam int AW = (LD > 1) ? $clog2(LD) : 1;
	localparam int CW = $clog2(CAPACITY+1);
	localparam int IW = AW + 2;

	typedef enum logic [2:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_WAIT, S_DN_CMP, S_DONE
	} sstate_t;

	logic [SAMPLE_WIDTH-1:0] lo_mem [LD];
	logic [SAMPLE_WIDTH-1:0] up_mem [UD];

	sstate_t st_q;
	logic    is_lo_q;
	logic    chain_q;
	logic [SAMPLE_WIDTH-1:0] v_q, carry_q, lc_q;
	logic [IW-1:0] i_q, sz_q;
	logic [SAMPLE_WIDTH-1:0] rd_q;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [SAMPLE_WIDTH-1:0] wr_data;
	logic wr_en;
	logic is_max;
	logic [IW-1:0] par, lch, rch;

	assign is_max = is_lo_q;
	assign par = (i_q - IW'(1)) >> 1;
	assign lch = (i_q << 1) + IW'(1);
	assign rch = (i_q << 1) + IW'(2);

	function automatic logic above(input logic [SAMPLE_WIDTH-1:0] a,
		input logic [SAMPLE_WIDTH-1:0] b, input logic mx);
		above = mx ? (a > b) : (a < b);
	endfunction

	// One port each: a registered read and a write per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (is_lo_q) lo_mem[wr_addr[AW-1:0]] <= wr_data;
			else up_mem[wr_addr[AW-1:0]] <= wr_data;
		end
		rd_q <= is_lo_q ? lo_mem[rd_addr[AW-1:0]] : up_mem[rd_addr[AW-1:0]];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = i_q;
		wr_data = v_q;
		rd_addr = i_q;
		unique case (st_q)
			S_UP_RD: rd_addr = par;
			S_UP_CMP: begin
				wr_en = 1'b1;
				if (i_q != '0 && above(v_q, rd_q, is_max)) wr_data = rd_q;
			end
			S_DN_RD: begin
				rd_addr = lch;
				// A leaf ends the descent, so the new value lands here.
				if (lch >= sz_q) wr_en = 1'b1;
			end
			S_DN_WAIT: rd_addr = rch;
			S_DN_CMP: begin
				wr_en = 1'b1;
				if (rch < sz_q && above(rd_q, lc_q, is_max)) begin
					if (above(rd_q, v_q, is_max)) wr_data = rd_q;
				end else if (above(lc_q, v_q, is_max)) begin
					wr_data = lc_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			lo_size <= '0;
			up_size <= '0;
			sts <= '0;
			is_lo_q <= 1'b0;
			chain_q <= 1'b0;
		end else begin
			sts.done <= (st_q == S_DONE) || (st_q == S_IDLE && cmd.start &&
				(cmd.op == OP_NONE || cmd.op == OP_LOAD));
			if (cmd.clear) begin
				lo_size <= '0;
				up_size <= '0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd.start) begin
						unique case (cmd.op)
							OP_PUSH_LO, OP_PUSH_UP: begin
								is_lo_q <= (cmd.op == OP_PUSH_LO);
								i_q <= (cmd.op == OP_PUSH_LO) ? IW'(lo_size) : IW'(up_size);
								if (cmd.op == OP_PUSH_LO) lo_size <= lo_size + CW'(1);
								else up_size <= up_size + CW'(1);
								// A push that follows a replace carries the displaced top.
								v_q <= chain_q ? carry_q : x;
								chain_q <= 1'b0;
								st_q <= S_UP_RD;
								sts.busy <= 1'b1;
							end
							OP_REPL_LO, OP_REPL_UP: begin
								is_lo_q <= (cmd.op == OP_REPL_LO);
								sz_q <= (cmd.op == OP_REPL_LO) ? IW'(lo_size) : IW'(up_size);
								carry_q <= (cmd.op == OP_REPL_LO) ? lo_top : up_top;
								chain_q <= 1'b1;
								i_q <= '0;
								v_q <= x;
								st_q <= S_DN_RD;
								sts.busy <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_UP_RD: st_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (i_q != '0 && above(v_q, rd_q, is_max)) begin
						i_q <= par;
						st_q <= S_UP_RD;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_DN_RD: begin
					if (lch >= sz_q) st_q <= S_DONE;
					else st_q <= S_DN_WAIT;
				end
				S_DN_WAIT: begin
					lc_q <= rd_q;
					st_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (rch < sz_q && above(rd_q, lc_q, is_max)) begin
						if (above(rd_q, v_q, is_max)) begin
							i_q <= rch;
							st_q <= S_DN_RD;
						end else st_q <= S_DONE;
					end else if (above(lc_q, v_q, is_max)) begin
						i_q <= lch;
						st_q <= S_DN_RD;
					end else st_q <= S_DONE;
				end
				S_DONE: begin
					sts.busy <= 1'b0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Tops are cached in registers so they are always readable.
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0) begin
			if (is_lo_q) lo_top <= wr_data;
			else up_top <= wr_data;
		end
	end
endmodule

// File: verif/rmth_checker.sv
// Checker that predicts the running median and compares every result word.
`timescale 1ns / 1ps
module rmth_checker #(
	parameter int CAPACITY = 1024,
	parameter int SAMPLE_WIDTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          pending
);
	localparam int LO_DEPTH = (CAPACITY + 1) / 2;
	localparam int UP_DEPTH = CAPACITY / 2;

	typedef struct packed {
		logic [19:0] mfloor;
		logic        half;
		logic [10:0] count;
		logic        ovf;
	} median_t;

	logic [31:0] lo_heap [LO_DEPTH];
	logic [31:0] up_heap [UP_DEPTH];
	int lo_n, up_n;
	median_t medians_due[$];

	function automatic bit above(logic [31:0] a, logic [31:0] b, bit is_max);
		return is_max ? (a > b) : (a < b);
	endfunction

	task automatic push_lo(logic [31:0] v);
		int i;
		int p;
		i = lo_n;
		if (i >= LO_DEPTH) return;
		lo_n++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!above(v, lo_heap[p], 1)) break;
			lo_heap[i] = lo_heap[p];
			i = p;
		end
		lo_heap[i] = v;
	endtask

	task automatic push_up(logic [31:0] v);
		int i;
		int p;
		i = up_n;
		if (i >= UP_DEPTH) return;
		up_n++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (!above(v, up_heap[p], 0)) break;
			up_heap[i] = up_heap[p];
			i = p;
		end
		up_heap[i] = v;
	endtask

	// Sift v down from the top of the chosen heap and return the old top.
	task automatic replace_top(bit is_max, logic [31:0] v, output logic [31:0] old);
		int i;
		int l;
		int best;
		int n;
		logic [31:0] hb;
		logic [31:0] hr;
		i = 0;
		n = is_max ? lo_n : up_n;
		old = is_max ? lo_heap[0] : up_heap[0];
		forever begin
			l = 2 * i + 1;
			if (l >= n) break;
			best = l;
			if (l + 1 < n) begin
				hr = is_max ? lo_heap[l+1] : up_heap[l+1];
				hb = is_max ? lo_heap[l] : up_heap[l];
				if (above(hr, hb, is_max)) best = l + 1;
			end
			hb = is_max ? lo_heap[best] : up_heap[best];
			if (!above(hb, v, is_max)) break;
			if (is_max) lo_heap[i] = hb; else up_heap[i] = hb;
			i = best;
		end
		if (is_max) lo_heap[i] = v; else up_heap[i] = v;
	endtask

	task automatic predict_median(logic [23:0] raw, logic fresh);
		logic [31:0] x;
		logic [31:0] moved;
		logic [32:0] sum;
		median_t r;
		x = raw & ((32'd1 << SAMPLE_WIDTH) - 1);
		r = '0;
		if (fresh) begin
			lo_n = 0;
			up_n = 0;
		end
		if (lo_n + up_n >= CAPACITY) r.ovf = 1'b1;
		else if (lo_n == 0) push_lo(x);
		else if (lo_n > up_n) begin
			if (x < lo_heap[0]) begin
				replace_top(1, x, moved);
				push_up(moved);
			end else push_up(x);
		end else begin
			if (x < lo_heap[0] || up_n == 0 || x <= up_heap[0]) push_lo(x);
			else begin
				replace_top(0, x, moved);
				push_lo(moved);
			end
		end
		if (lo_n > 0) begin
			if (lo_n == up_n) begin
				sum = lo_heap[0] + up_heap[0];
				r.mfloor = sum[20:1];
				r.half = sum[0];
			end else r.mfloor = lo_heap[0][19:0];
		end
		r.count = 11'(lo_n + up_n);
		medians_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		median_t e;
		if (!arst_n) begin
			lo_n = 0;
			up_n = 0;
			errors = 0;
			medians_due.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (medians_due.size() == 0) begin
					$error("unexpected result word %h", m_tdata);
					errors = errors + 1;
				end else begin
					e = medians_due.pop_front();
					if (m_tdata[19:0] !== e.mfloor) begin
						$error("median_floor exp %0d got %0d", e.mfloor, m_tdata[19:0]);
						errors = errors + 1;
					end
					if (m_tdata[20] !== e.half) begin
						$error("median_has_half exp %0d got %0d", e.half, m_tdata[20]);
						errors = errors + 1;
					end
					if (m_tdata[31:21] !== e.count) begin
						$error("stream_count exp %0d got %0d", e.count, m_tdata[31:21]);
						errors = errors + 1;
					end
					if (m_tuser !== e.ovf) begin
						$error("overflow exp %0d got %0d", e.ovf, m_tuser);
						errors = errors + 1;
					end
				end
			end
			if (s_tvalid && s_tready) predict_median(s_tdata, s_tuser);
		end
		pending = medians_due.size();
	end
endmodule

// File: verif/tb_top.sv
// Top of the running median testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic m_tuser;
	int errors, pending;
	int quiet = 0;
	bit calm = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	running_median_two_heaps dut (.*);
	rmth_checker chk (.*);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("running_median_two_heaps verification failed");
			$finish;
		end
	end

	// Receiver stalls in bursts until the calm tail of the run.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 17);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	task automatic send_word(logic [23:0] d, logic fresh);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= fresh;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [23:0] rnd_sample();
		case ($urandom_range(0, 4))
			0: return 24'($urandom_range(0, 15));
			1: return 24'(24'hFFFFF - $urandom_range(0, 15));
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 24'hFFFFF));
		endcase
	endfunction

	initial begin
		int len;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Extremes, wide-sample bits, duplicates and a short fresh stream.
		send_word(24'h000000, 1'b1);
		send_word(24'h0FFFFF, 1'b0);
		send_word(24'hF00000, 1'b0);
		send_word(24'hFFFFFF, 1'b0);
		send_word(24'h000001, 1'b0);
		send_word(24'h000001, 1'b0);
		send_word(24'h0FFFFE, 1'b1);
		send_word(24'h0FFFFF, 1'b0);
		send_word(24'h000000, 1'b0);
		send_word(24'h080000, 1'b0);
		// Fill the store, overflow on the next words, then restart while full.
		send_word(rnd_sample(), 1'b1);
		repeat (1023) send_word(rnd_sample(), 1'b0);
		repeat (4) send_word(rnd_sample(), 1'b0);
		send_word(rnd_sample(), 1'b1);
		repeat (3) send_word(rnd_sample(), 1'b0);
		// Random short streams.
		repeat (30) begin
			len = $urandom_range(1, 12);
			send_word(rnd_sample(), 1'b1);
			repeat (len) send_word(rnd_sample(), $urandom_range(0, 19) == 0);
		end
		calm = 1;
		repeat (40) send_word(rnd_sample(), $urandom_range(0, 9) == 0);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("running_median_two_heaps verification clean");
		else $display("running_median_two_heaps verification failed");
		$finish;
	end
endmodule
